// ----- sv/lz_pkg.sv -----
// Shared types, register codes and saturating add for the Lorenz Euler integrator.
package lz_pkg;

  localparam int FRAC_BITS_DEF = 20;
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 5;
  localparam int REG_IDX_W     = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SIGMA   = 3'd0,
    REG_RHO     = 3'd1,
    REG_BETA    = 3'd2,
    REG_DT      = 3'd3,
    REG_START_X = 3'd4,
    REG_START_Y = 3'd5,
    REG_START_Z = 3'd6
  } cfg_reg_e;

  // Clamped 32-bit value with its saturation flag.
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } lz_res_t;

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Add or subtract two signed words and clamp to the signed 32-bit range.
  function automatic lz_res_t add_sat(input logic signed [DATA_W-1:0] a,
                                      input logic signed [DATA_W-1:0] b,
                                      input logic                     sub);
    logic signed [DATA_W:0] s;
    lz_res_t                r;
    s = sub ? ($signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b}))
            : ($signed({a[DATA_W-1], a}) + $signed({b[DATA_W-1], b}));
    r.sat = s[DATA_W] != s[DATA_W-1];
    if (r.sat) begin
      r.val = s[DATA_W] ? S_MIN : S_MAX;
    end else begin
      r.val = s[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/lz_fmul.sv -----
// Shared fixed-point multiplier: registered 32x32 product, then floor shift and clamp.
module lz_fmul
  import lz_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic signed [DATA_W-1:0] op_a_i,
  input  logic signed [DATA_W-1:0] op_b_i,
  output lz_res_t                  res_o
);

  localparam int PROD_W = 2 * DATA_W;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] shifted;
  logic                     all_ones;
  logic                     all_zeros;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  // Arithmetic shift floors toward minus infinity.
  assign shifted   = prod_q >>> FRAC_BITS;
  assign all_ones  = &shifted[PROD_W-1:DATA_W-1];
  assign all_zeros = ~|shifted[PROD_W-1:DATA_W-1];

  always_comb begin
    res_o.sat = !(all_ones || all_zeros);
    if (res_o.sat) begin
      res_o.val = shifted[PROD_W-1] ? S_MIN : S_MAX;
    end else begin
      res_o.val = shifted[DATA_W-1:0];
    end
  end

endmodule

// ----- sv/lorenz_euler_step_top.sv -----
// Top level of the Lorenz Euler integrator: APB registers, step sequencer, output register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | in        | in_valid_i / in_stall_o   | restart_i
//  out     | out       | out_valid_o / out_stall_i | pos_x_o, pos_y_o, pos_z_o, saturated_o
//  cfg     | in        | APB write, pready = 1     | paddr[4:2] register, pwdata
//
// A tick item occupies nine sequencer slots on the single multiplier and the single
// saturating adder, plus one slot to load the output register; the next item can be
// taken only once the sequencer is back in idle. A restart item loads the start point
// and goes straight to the slot that loads the output register.
// in_stall_o is high whenever the sequencer is not idle; one item is in work at a time.
// A waiting result does not block acceptance; the sequencer holds in its last slot only
// when the previous result is still stalled. Reset loads the default coefficients and
// the start point 1.0; no clearing pass is needed.
module lorenz_euler_step_top
  import lz_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     restart_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] pos_x_o,
  output logic signed [DATA_W-1:0] pos_y_o,
  output logic signed [DATA_W-1:0] pos_z_o,
  output logic                     saturated_o,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int GAIN_W = 31;
  localparam int DT_W   = 21;

  // Reset values scaled by 2^FRAC_BITS, rounded, masked to register width.
  localparam logic [63:0] ONE       = 64'(1) << FRAC_BITS;
  localparam logic [63:0] SIGMA_RST = 64'd10 * ONE;
  localparam logic [63:0] RHO_RST   = 64'd28 * ONE;
  localparam logic [63:0] BETA_RST  = (64'd8 * ONE + 64'd1) / 64'd3;
  localparam logic [63:0] DT_RST    = (ONE + 64'd50) / 64'd100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_C8, ST_C9,
    ST_DONE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [GAIN_W-1:0]        sigma_q, rho_q, beta_q;
  logic [DT_W-1:0]          dt_q;
  logic signed [DATA_W-1:0] start_x_q, start_y_q, start_z_q;

  // Point state and step temporaries.
  logic signed [DATA_W-1:0] cur_x_q, cur_y_q, cur_z_q;
  logic signed [DATA_W-1:0] a_q, b_q, xy_q, bz_q, rx_q, p_q, rz_q, ry_q;
  logic signed [DATA_W-1:0] dx_q, dy_q, dz_q, nx_q, nz_q;
  logic                     sat_q;

  // Output register.
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic                     saturated_q;

  // Shared unit operands.
  logic signed [DATA_W-1:0] mul_a, mul_b, add_a, add_b;
  logic                     add_sub, add_use, mul_use;
  lz_res_t                  mul_res, add_res;

  logic                     cfg_wr;
  cfg_reg_e                 cfg_idx;
  logic                     in_acc, out_free;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = cfg_reg_e'(paddr[ADDR_W-1:2]);
  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Register read back.
  always_comb begin
    unique case (cfg_idx)
      REG_SIGMA:   prdata = {1'b0, sigma_q};
      REG_RHO:     prdata = {1'b0, rho_q};
      REG_BETA:    prdata = {1'b0, beta_q};
      REG_DT:      prdata = {{(DATA_W-DT_W){1'b0}}, dt_q};
      REG_START_X: prdata = start_x_q;
      REG_START_Y: prdata = start_y_q;
      REG_START_Z: prdata = start_z_q;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q   <= SIGMA_RST[GAIN_W-1:0];
      rho_q     <= RHO_RST[GAIN_W-1:0];
      beta_q    <= BETA_RST[GAIN_W-1:0];
      dt_q      <= DT_RST[DT_W-1:0];
      start_x_q <= ONE[DATA_W-1:0];
      start_y_q <= ONE[DATA_W-1:0];
      start_z_q <= ONE[DATA_W-1:0];
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SIGMA:   sigma_q   <= pwdata[GAIN_W-1:0];
        REG_RHO:     rho_q     <= pwdata[GAIN_W-1:0];
        REG_BETA:    beta_q    <= pwdata[GAIN_W-1:0];
        REG_DT:      dt_q      <= pwdata[DT_W-1:0];
        REG_START_X: start_x_q <= pwdata;
        REG_START_Y: start_y_q <= pwdata;
        REG_START_Z: start_z_q <= pwdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Operand selection for the shared multiplier and adder, one slot per state.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    add_use = 1'b0;
    mul_use = 1'b0;
    unique case (state_q)
      ST_C1: begin
        mul_a = cur_x_q; mul_b = cur_y_q;
        add_a = cur_y_q; add_b = cur_x_q; add_sub = 1'b1; add_use = 1'b1;
      end
      ST_C2: begin
        mul_use = 1'b1;
        mul_a = $signed({1'b0, beta_q}); mul_b = cur_z_q;
        add_a = $signed({1'b0, rho_q}); add_b = cur_z_q; add_sub = 1'b1; add_use = 1'b1;
      end
      ST_C3: begin
        mul_use = 1'b1;
        mul_a = $signed({1'b0, sigma_q}); mul_b = a_q;
      end
      ST_C4: begin
        mul_use = 1'b1;
        mul_a = cur_x_q; mul_b = b_q;
        add_a = xy_q; add_b = bz_q; add_sub = 1'b1; add_use = 1'b1;
      end
      ST_C5: begin
        mul_use = 1'b1;
        mul_a = rx_q; mul_b = $signed({{(DATA_W-DT_W){1'b0}}, dt_q});
      end
      ST_C6: begin
        mul_use = 1'b1;
        mul_a = rz_q; mul_b = $signed({{(DATA_W-DT_W){1'b0}}, dt_q});
        add_a = p_q; add_b = cur_y_q; add_sub = 1'b1; add_use = 1'b1;
      end
      ST_C7: begin
        mul_use = 1'b1;
        mul_a = ry_q; mul_b = $signed({{(DATA_W-DT_W){1'b0}}, dt_q});
        add_a = cur_x_q; add_b = dx_q; add_use = 1'b1;
      end
      ST_C8: begin
        mul_use = 1'b1;
        add_a = cur_z_q; add_b = dz_q; add_use = 1'b1;
      end
      ST_C9: begin
        add_a = cur_y_q; add_b = dy_q; add_use = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_res = add_sat(add_a, add_b, add_sub);

  lz_fmul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fmul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .res_o  (mul_res)
  );

  // Temporaries carry payload only; no reset.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_C1: a_q  <= add_res.val;
      ST_C2: begin xy_q <= mul_res.val; b_q  <= add_res.val; end
      ST_C3: bz_q <= mul_res.val;
      ST_C4: begin rx_q <= mul_res.val; rz_q <= add_res.val; end
      ST_C5: p_q  <= mul_res.val;
      ST_C6: begin dx_q <= mul_res.val; ry_q <= add_res.val; end
      ST_C7: begin dz_q <= mul_res.val; nx_q <= add_res.val; end
      ST_C8: begin dy_q <= mul_res.val; nz_q <= add_res.val; end
      default: ;
    endcase
  end

  // Sequencer, point state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_x_q     <= ONE[DATA_W-1:0];
      cur_y_q     <= ONE[DATA_W-1:0];
      cur_z_q     <= ONE[DATA_W-1:0];
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      saturated_q <= 1'b0;
    end else begin
      // Drop the shown result once the sink takes it; the last slot reloads it itself.
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      // Collect clamps from both shared units.
      if (state_q != ST_IDLE && state_q != ST_DONE) begin
        sat_q <= sat_q | (add_use & add_res.sat) | (mul_use & mul_res.sat);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            sat_q <= 1'b0;
            if (restart_i) begin
              cur_x_q <= start_x_q;
              cur_y_q <= start_y_q;
              cur_z_q <= start_z_q;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_C1;
            end
          end
        end
        ST_C1: state_q <= ST_C2;
        ST_C2: state_q <= ST_C3;
        ST_C3: state_q <= ST_C4;
        ST_C4: state_q <= ST_C5;
        ST_C5: state_q <= ST_C6;
        ST_C6: state_q <= ST_C7;
        ST_C7: state_q <= ST_C8;
        ST_C8: state_q <= ST_C9;
        ST_C9: begin
          // Commit the new point from the old one, all three coordinates at once.
          cur_x_q <= nx_q;
          cur_y_q <= add_res.val;
          cur_z_q <= nz_q;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // Hold here while the previous result is still stalled.
          if (out_free) begin
            out_valid_q <= 1'b1;
            pos_x_q     <= cur_x_q;
            pos_y_q     <= cur_y_q;
            pos_z_q     <= cur_z_q;
            saturated_q <= sat_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign pos_z_o     = pos_z_q;
  assign saturated_o = saturated_q;

  // A tick enters the first slot of the schedule.
  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !restart_i) |=> state_q == ST_C1)
    else $error("tick did not start the step schedule");

  // A restart loads the start point with a clear flag.
  a_restart_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && restart_i) |=> (cur_x_q == $past(start_x_q) && cur_z_q == $past(start_z_q)
                               && !sat_q && state_q == ST_DONE))
    else $error("restart did not load the start point");

  // Leaving the last slot shows the current point.
  a_done_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && pos_x_q == cur_x_q
                                          && pos_y_q == cur_y_q && state_q == ST_IDLE))
    else $error("result register not loaded from the point");

  // The sequencer never overwrites a result the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && state_q == ST_DONE) |=> state_q == ST_DONE)
    else $error("sequencer left the last slot while the result was stalled");

endmodule

// ----- sim/lz_checker.sv -----
// Checker for the Lorenz Euler integrator: follows register writes, predicts points, compares.
`timescale 1ns / 100ps
module lz_checker
  import lz_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     restart_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [DATA_W-1:0] pos_x_i,
  input  logic signed [DATA_W-1:0] pos_y_i,
  input  logic signed [DATA_W-1:0] pos_z_i,
  input  logic                     saturated_i,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic                     pready_i,
  input  logic [ADDR_W-1:0]        paddr_i,
  input  logic [DATA_W-1:0]        pwdata_i,
  output int                       errors_o,
  output int                       pending_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic                     sat;
  } point_t;

  localparam longint ONE = longint'(1) << FRAC_BITS;

  logic [30:0]              sigma_q;
  logic [30:0]              rho_q;
  logic [30:0]              beta_q;
  logic [20:0]              dt_q;
  logic signed [DATA_W-1:0] start_x_q;
  logic signed [DATA_W-1:0] start_y_q;
  logic signed [DATA_W-1:0] start_z_q;
  logic signed [DATA_W-1:0] cur_x;
  logic signed [DATA_W-1:0] cur_y;
  logic signed [DATA_W-1:0] cur_z;
  logic                     step_sat;
  point_t                   expected_points[$];
  int                       mismatches = 0;

  assign errors_o = mismatches;

  // Clamp to the signed word range and note any clamp for this step.
  function automatic logic signed [DATA_W-1:0] clip(input longint v);
    if (v > longint'(S_MAX)) begin
      step_sat = 1'b1;
      return S_MAX;
    end
    if (v < longint'(S_MIN)) begin
      step_sat = 1'b1;
      return S_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  // Exact product, floor shift by the fraction width, then clamp.
  function automatic logic signed [DATA_W-1:0] fix_mul(input longint a, input longint b);
    return clip((a * b) >>> FRAC_BITS);
  endfunction

  // Move the held point by one item and return the point the block must show.
  function automatic point_t lorenz_advance(input logic reload);
    point_t p;
    longint x, y, z, rx, ry, rz;
    step_sat = 1'b0;
    if (reload) begin
      cur_x = start_x_q;
      cur_y = start_y_q;
      cur_z = start_z_q;
    end else begin
      x  = cur_x;
      y  = cur_y;
      z  = cur_z;
      rx = fix_mul(longint'(sigma_q), clip(y - x));
      ry = clip(fix_mul(x, clip(longint'(rho_q) - z)) - y);
      rz = clip(longint'(fix_mul(x, y)) - fix_mul(longint'(beta_q), z));
      cur_x = clip(x + fix_mul(rx, longint'(dt_q)));
      cur_y = clip(y + fix_mul(ry, longint'(dt_q)));
      cur_z = clip(z + fix_mul(rz, longint'(dt_q)));
    end
    p.x   = cur_x;
    p.y   = cur_y;
    p.z   = cur_z;
    p.sat = step_sat;
    return p;
  endfunction

  function automatic void compare_field(input string field, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    point_t want;
    if (!rst_ni) begin
      sigma_q   = 31'(10 * ONE);
      rho_q     = 31'(28 * ONE);
      beta_q    = 31'((8 * ONE + 1) / 3);
      dt_q      = 21'((ONE + 50) / 100);
      start_x_q = 32'(ONE);
      start_y_q = 32'(ONE);
      start_z_q = 32'(ONE);
      cur_x     = 32'(ONE);
      cur_y     = 32'(ONE);
      cur_z     = 32'(ONE);
      expected_points.delete();
      pending_o <= 0;
    end else begin
      // results first: a result can never belong to an item taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual x=%h y=%h z=%h sat=%b",
                   $time, pos_x_i, pos_y_i, pos_z_i, saturated_i);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          compare_field("pos_x", want.x, pos_x_i);
          compare_field("pos_y", want.y, pos_y_i);
          compare_field("pos_z", want.z, pos_z_i);
          compare_field("saturated", DATA_W'(want.sat), DATA_W'(saturated_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_points.insert(expected_points.size(), lorenz_advance(restart_i));
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[REG_IDX_W+1:2])
          REG_SIGMA:   sigma_q   = pwdata_i[30:0];
          REG_RHO:     rho_q     = pwdata_i[30:0];
          REG_BETA:    beta_q    = pwdata_i[30:0];
          REG_DT:      dt_q      = pwdata_i[20:0];
          REG_START_X: start_x_q = pwdata_i;
          REG_START_Y: start_y_q = pwdata_i;
          REG_START_Z: start_z_q = pwdata_i;
          default: ;
        endcase
      end
      pending_o <= expected_points.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the Lorenz Euler integrator: clock, reset, stimulus, register set-up, verdict.
`timescale 1ns / 100ps
module tb;
  import lz_pkg::*;

  // Abort when nothing moves on any channel for this many cycles. The slowest honest
  // stretch is the long receiver hold plus one step.
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  // Wait after the drain so that stray results get a chance to show.
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 290;
  localparam int NUM_PHASES    = 6;

  // Address slot past the last register: writes there must be dropped.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [DATA_W-1:0]    Q_ONE     = 1 << FRAC_BITS_DEF;

  typedef enum int {SET_DEFAULT, SET_NEAR, SET_WILD} setting_e;
  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_e;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic                     restart   = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] pos_z;
  logic                     saturated;
  logic                     psel      = 1'b0;
  logic                     penable   = 1'b0;
  logic                     pwrite    = 1'b0;
  logic [ADDR_W-1:0]        paddr     = '0;
  logic [DATA_W-1:0]        pwdata    = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  int   errors;
  int   pending;
  int   quiet_cycles = 0;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  // Long hold request: flip hold_req, the receiver answers by copying it to hold_ack.
  logic hold_req     = 1'b0;
  logic hold_ack     = 1'b0;
  int   hold_left    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lorenz_euler_step_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .restart_i   (restart),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y),
    .pos_z_o     (pos_z),
    .saturated_o (saturated),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  lz_checker point_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .restart_i   (restart),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .pos_z_i     (pos_z),
    .saturated_i (saturated),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Receiver: a long hold when asked, otherwise random stalls at the current rate.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_ack  <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Watchdog: count cycles in which no item, result or register write is taken.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one item after a random gap; return once the block has taken it.
  // Keep valid high across back-to-back items so it is never dropped and raised in one step.
  task automatic offer_item(input logic reload);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= reload;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted point has come back.
  // Skip one edge first: the checker's count lags the edge it was updated on.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Setup cycle then access cycle. Leave psel high so that a following write can
  // start in the same step without lowering and raising it.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Write every register (plus a throwaway write to the unused slot), then release the bus.
  task automatic write_all(input logic [DATA_W-1:0] sg, input logic [DATA_W-1:0] rh,
                           input logic [DATA_W-1:0] bt, input logic [DATA_W-1:0] dt,
                           input logic [DATA_W-1:0] sx, input logic [DATA_W-1:0] sy,
                           input logic [DATA_W-1:0] sz);
    write_reg(REG_SPARE, $urandom());
    write_reg(REG_SIGMA, sg);
    write_reg(REG_RHO, rh);
    write_reg(REG_BETA, bt);
    write_reg(REG_DT, dt);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_START_Z, sz);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A start coordinate within +/-40.0, where the attractor stays in range.
  function automatic logic [DATA_W-1:0] near_coord();
    return $urandom_range(0, 80 * Q_ONE) - 40 * Q_ONE;
  endfunction

  task automatic load_settings(input setting_e pick);
    case (pick)
      SET_DEFAULT: write_all(10 * Q_ONE, 28 * Q_ONE, (8 * Q_ONE + 1) / 3, (Q_ONE + 50) / 100,
                             Q_ONE, Q_ONE, Q_ONE);
      // coefficients around the classic ones, dt up to about 0.03
      SET_NEAR:    write_all($urandom_range(0, 20 * Q_ONE), $urandom_range(0, 50 * Q_ONE),
                             $urandom_range(0, 5 * Q_ONE), $urandom_range(0, Q_ONE / 32),
                             near_coord(), near_coord(), near_coord());
      // every bit of every register at random: saturation all over
      default:     write_all($urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom());
    endcase
  endtask

  initial begin
    setting_e pick;

    // Hold reset, then release it at an edge.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ticks straight from the reset point, then a restart and more ticks.
    offer_item(1'b0);
    offer_item(1'b0);
    offer_item(1'b1);
    offer_item(1'b0);
    offer_item(1'b0);

    // Full-scale coefficients (written all ones to check the width masks), dt above 1.0,
    // start point at opposite corners so that y - x clamps straight away.
    drain();
    write_all('1, '1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    offer_item(1'b1);
    offer_item(1'b0);
    offer_item(1'b0);
    offer_item(1'b0);

    drain();
    write_all('1, '1, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer_item(1'b1);
    offer_item(1'b0);
    offer_item(1'b0);

    // All zero: ticks must leave the point where it is.
    drain();
    write_all('0, '0, '0, '0, '0, '0, '0);
    offer_item(1'b0);
    offer_item(1'b1);
    offer_item(1'b0);

    // Classic coefficients with dt at 1.0: diverges fast.
    drain();
    write_all(10 * Q_ONE, 28 * Q_ONE, (8 * Q_ONE + 1) / 3, Q_ONE, 3 * Q_ONE, -Q_ONE,
              20 * Q_ONE);
    offer_item(1'b1);
    repeat (4) offer_item(1'b0);

    // Random part: mostly long runs of ticks so trajectories wander deep into the
    // attractor, with the odd restart. Cycle through the idling patterns per phase.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        pick = SET_DEFAULT;
      end else if (ph == 3) begin
        pick = SET_WILD;
      end else begin
        pick = SET_NEAR;
      end
      load_settings(pick);
      case (idle_e'(ph % 4))
        IDLE_NONE: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        IDLE_TX: begin
          tx_idle_pct  = 82;
          rx_stall_pct = 0;
        end
        IDLE_RX: begin
          tx_idle_pct  = 82 - 82;
          rx_stall_pct = 82;
        end
        default: begin
          tx_idle_pct  = 36;
          rx_stall_pct = 36;
        end
      endcase
      // Hold the receiver off for a long stretch while items keep coming, so the
      // output register fills and the block has to stall its input.
      if (ph == 2) begin
        hold_req <= ~hold_req;
      end
      repeat (PHASE_ITEMS) offer_item($urandom_range(0, 31) == 0);
    end

    // Let everything come back, then give stray results a chance to show.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
